// ===== src/icmp_cs_pkg.sv =====
package icmp_cs_pkg;

    // Width of the message byte counter (saturating)
    localparam int LENGTH_BITS = 16;

    // Width of the ones' complement sum
    localparam int SUM_W = 16;

    // IPv6 next-header value for ICMPv6
    localparam logic [SUM_W-1:0] ICMPV6_NEXT_HDR = 16'd58;

    typedef logic [SUM_W-1:0]       sum_t;
    typedef logic [LENGTH_BITS-1:0] count_t;

    localparam count_t COUNT_MAX = {LENGTH_BITS{1'b1}};

    // End-of-message record handed from the accumulator to the final stage
    typedef struct packed {
        sum_t   sum;
        count_t count;
        logic   overflow;
    } msg_total_t;

    // Ones' complement add with end-around carry
    function automatic sum_t oc_add(input sum_t a, input sum_t b);
        logic [SUM_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            oc_add = s[SUM_W-1:0] + sum_t'(s[SUM_W]);
        end
    endfunction

endpackage

// ===== src/icmp_internet_checksum.sv =====
// Internet checksum (ones' complement sum) over ICMP messages, with an
// optional IPv6 pseudo-header (message length and next header 58).
// Input channel: in_valid / in_stall carry cmd, word, single_byte, last;
// one word is transferred per cycle when in_stall is low. Address words of
// the pseudo-header use cmd = 1 and are summed but not counted.
// Output channel: out_valid / out_stall carry checksum, checksum_ok and
// too_long, one result per message, on its last word.
// Config channel: cfg_valid / cfg_ready write ipv6_mode from cfg_data;
// cfg_ready is always high. Write only while no message is in flight.
// Throughput: one word per cycle while out_stall is low, sustained, back to
// back across messages. The result of a message passes the input register,
// then the accumulator/end-of-message record, then the pseudo-header add
// and fold into the output register.
// Reset clears ipv6_mode, the running sum, byte count and overflow flag
// and empties all stages. When out_stall is held, the pipeline keeps
// taking non-last words; in_stall rises once a last word cannot be
// handed on, and the held result stays unchanged.
module icmp_internet_checksum
    import icmp_cs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [15:0] word,
    input  logic        single_byte,
    input  logic        last,
    // results
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] checksum,
    output logic        checksum_ok,
    output logic        too_long
);

    logic       ipv6_mode_reg;
    logic       total_valid;
    msg_total_t total;
    logic       total_take;

    assign cfg_ready = 1'b1;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipv6_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ipv6_mode_reg <= cfg_data;
        end
    end

    icmp_cs_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .word        (word),
        .single_byte (single_byte),
        .last        (last),
        .total_valid (total_valid),
        .total       (total),
        .total_take  (total_take)
    );

    icmp_cs_final u_final (
        .clk         (clk),
        .rst_n       (rst_n),
        .ipv6_mode   (ipv6_mode_reg),
        .total_valid (total_valid),
        .total       (total),
        .total_take  (total_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .checksum    (checksum),
        .checksum_ok (checksum_ok),
        .too_long    (too_long)
    );

endmodule

// ===== src/icmp_cs_accum.sv =====
module icmp_cs_accum
    import icmp_cs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input item channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [15:0] word,
    input  logic       single_byte,
    input  logic       last,
    // end-of-message record toward the final stage
    output logic       total_valid,
    output msg_total_t total,
    input  logic       total_take
);

    // input register
    logic        s1_valid_reg;
    logic        s1_cmd_reg;
    logic [15:0] s1_word_reg;
    logic        s1_single_reg;
    logic        s1_last_reg;

    // running message state
    sum_t   sum_reg,   sum_next;
    count_t count_reg, count_next;
    logic   ovf_reg,   ovf_next;

    // end-of-message record register
    logic       total_valid_reg, total_valid_next;
    msg_total_t total_reg,       total_next;

    logic              consume;
    logic              s1_ready;
    logic              total_free;
    logic [15:0]       word_pad;
    sum_t              sum_upd;
    logic [LENGTH_BITS:0] count_sum;
    count_t            count_upd;
    logic              ovf_upd;
    count_t            count_inc;

    // record slot frees when the final stage takes it
    assign total_free = !total_valid_reg || total_take;
    // a non-last item never waits; a last item needs the record slot
    assign consume    = s1_valid_reg && (!s1_last_reg || total_free);
    assign s1_ready   = !s1_valid_reg || consume;
    assign in_stall   = !s1_ready;

    // pad a lone byte with a zero low byte
    assign word_pad = s1_single_reg ? {s1_word_reg[15:8], 8'h00} : s1_word_reg;
    assign sum_upd  = oc_add(sum_reg, word_pad);

    // saturating byte count; address words are not counted
    always_comb
    begin
        if (s1_cmd_reg)
        begin
            count_inc = '0;
        end
        else if (s1_single_reg)
        begin
            count_inc = count_t'(1);
        end
        else
        begin
            count_inc = count_t'(2);
        end
        count_sum = {1'b0, count_reg} + {1'b0, count_inc};
        if (count_sum[LENGTH_BITS])
        begin
            count_upd = COUNT_MAX;
            ovf_upd   = 1'b1;
        end
        else
        begin
            count_upd = count_sum[LENGTH_BITS-1:0];
            ovf_upd   = ovf_reg;
        end
    end

    // state update and end-of-message hand-off
    always_comb
    begin
        sum_next         = sum_reg;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        total_next       = total_reg;
        total_valid_next = total_valid_reg && !total_take;
        if (consume)
        begin
            if (s1_last_reg)
            begin
                total_next.sum      = sum_upd;
                total_next.count    = count_upd;
                total_next.overflow = ovf_upd;
                total_valid_next    = 1'b1;
                sum_next            = '0;
                count_next          = '0;
                ovf_next            = 1'b0;
            end
            else
            begin
                sum_next   = sum_upd;
                count_next = count_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            total_valid_reg <= 1'b0;
            sum_reg         <= '0;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            total_valid_reg <= total_valid_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            ovf_reg         <= ovf_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_cmd_reg    <= cmd;
            s1_word_reg   <= word;
            s1_single_reg <= single_byte;
            s1_last_reg   <= last;
        end
        total_reg <= total_next;
    end

    assign total_valid = total_valid_reg;
    assign total       = total_reg;

endmodule

// ===== src/icmp_cs_final.sv =====
module icmp_cs_final
    import icmp_cs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ipv6_mode,
    // end-of-message record
    input  logic        total_valid,
    input  msg_total_t  total,
    output logic        total_take,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] checksum,
    output logic        checksum_ok,
    output logic        too_long
);

    logic        out_valid_reg;
    logic [15:0] checksum_reg, checksum_next;
    logic        ok_reg, ok_next;
    logic        too_long_reg;
    logic        out_ready;

    logic [31:0]      len32;
    logic [SUM_W+1:0] wide_sum;
    logic [SUM_W:0]   fold1;
    sum_t             fold2;

    assign out_ready  = !out_valid_reg || !out_stall;
    assign total_take = total_valid && out_ready;

    // pseudo-header: 32-bit length as two words plus next header,
    // summed at once and folded twice (same result as chained adds)
    assign len32 = 32'(total.count);

    always_comb
    begin
        if (ipv6_mode)
        begin
            wide_sum = {2'b00, total.sum} + {2'b00, len32[31:16]}
                     + {2'b00, len32[15:0]} + {2'b00, ICMPV6_NEXT_HDR};
        end
        else
        begin
            wide_sum = {2'b00, total.sum};
        end
        fold1         = {1'b0, wide_sum[SUM_W-1:0]} + (SUM_W+1)'(wide_sum[SUM_W+1:SUM_W]);
        fold2         = fold1[SUM_W-1:0] + sum_t'(fold1[SUM_W]);
        checksum_next = ~fold2;
        ok_next       = (checksum_next == '0);
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= total_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (total_take)
        begin
            checksum_reg <= checksum_next;
            ok_reg       <= ok_next;
            too_long_reg <= total.overflow;
        end
    end

    assign out_valid   = out_valid_reg;
    assign checksum    = checksum_reg;
    assign checksum_ok = ok_reg;
    assign too_long    = too_long_reg;

endmodule

// ===== dv/tb.sv =====
module tb;
    import icmp_cs_pkg::*;

    // Command and mode codes
    localparam logic CMD_MSG  = 1'b0;
    localparam logic CMD_ADDR = 1'b1;
    localparam logic MODE_V4  = 1'b0;
    localparam logic MODE_V6  = 1'b1;

    // Pause before a register write, longer than the result latency
    localparam int DRAIN_CYCLES = 6;
    localparam int NUM_DIR      = 22;

    typedef struct packed {
        logic        cmd;
        logic [15:0] word;
        logic        single_byte;
        logic        last;
    } word_item_t;

    typedef struct packed {
        sum_t chk;
        logic ok;
        logic too_long;
    } cs_result_t;

    typedef struct packed {
        sum_t   sum;
        count_t count;
        logic   ovf;
    } msg_acc_t;

    typedef struct packed {
        logic       mode;
        word_item_t item;
        logic       typed;
        cs_result_t res;
    } dir_row_t;

    localparam cs_result_t NO_RES = '0;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [15:0] word;
    logic        single_byte;
    logic        last;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] checksum;
    logic        checksum_ok;
    logic        too_long;

    // Predictor state and expected checksums in arrival order
    msg_acc_t   msg_acc = '0;
    logic       mode_cfg = MODE_V4;
    cs_result_t cs_expect_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int ok_seen        = 0;
    int long_seen      = 0;
    int cfg_writes     = 0;

    // Directed stimulus; expected values typed in only where obvious
    dir_row_t dir_tbl [0:NUM_DIR-1] = '{
        // all-zero word, then all-ones word that verifies
        '{MODE_V4, '{CMD_MSG,  16'h0000, 1'b0, 1'b1}, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
        '{MODE_V4, '{CMD_MSG,  16'hFFFF, 1'b0, 1'b1}, 1'b1, '{16'h0000, 1'b1, 1'b0}},
        // lone byte: low half dropped
        '{MODE_V4, '{CMD_MSG,  16'hFFFF, 1'b1, 1'b1}, 1'b1, '{16'h00FF, 1'b0, 1'b0}},
        // end-around carry
        '{MODE_V4, '{CMD_MSG,  16'h8000, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{MODE_V4, '{CMD_MSG,  16'h8000, 1'b0, 1'b1}, 1'b1, '{16'hFFFE, 1'b0, 1'b0}},
        // odd byte in the middle of a message
        '{MODE_V4, '{CMD_MSG,  16'h12AB, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{MODE_V4, '{CMD_MSG,  16'h3400, 1'b0, 1'b1}, 1'b0, NO_RES},
        // address words still summed in v4 mode, padded when single
        '{MODE_V4, '{CMD_ADDR, 16'hABCD, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{MODE_V4, '{CMD_ADDR, 16'h00FF, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{MODE_V4, '{CMD_MSG,  16'h0102, 1'b0, 1'b1}, 1'b0, NO_RES},
        '{MODE_V4, '{CMD_ADDR, 16'hFFFF, 1'b0, 1'b1}, 1'b0, NO_RES},
        // v6: length and next header added
        '{MODE_V6, '{CMD_MSG,  16'h0000, 1'b0, 1'b1}, 1'b0, NO_RES},
        '{MODE_V6, '{CMD_MSG,  16'hFFC3, 1'b0, 1'b1}, 1'b1, '{16'h0000, 1'b1, 1'b0}},
        '{MODE_V6, '{CMD_ADDR, 16'h2001, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{MODE_V6, '{CMD_ADDR, 16'h0DB8, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{MODE_V6, '{CMD_ADDR, 16'hFFFF, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{MODE_V6, '{CMD_MSG,  16'hFFFF, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{MODE_V6, '{CMD_MSG,  16'h00FF, 1'b1, 1'b1}, 1'b0, NO_RES},
        // only address words: zero length
        '{MODE_V6, '{CMD_ADDR, 16'h0000, 1'b0, 1'b1}, 1'b0, NO_RES},
        // two odd bytes in one message
        '{MODE_V6, '{CMD_MSG,  16'hFFFF, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{MODE_V6, '{CMD_MSG,  16'h5A5A, 1'b1, 1'b1}, 1'b0, NO_RES},
        '{MODE_V4, '{CMD_MSG,  16'h1234, 1'b0, 1'b1}, 1'b0, NO_RES}
    };

    icmp_internet_checksum u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .word        (word),
        .single_byte (single_byte),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .checksum    (checksum),
        .checksum_ok (checksum_ok),
        .too_long    (too_long)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ones' complement add, end-around carry folded once
    function automatic sum_t ones_add(input sum_t a, input sum_t b);
        int unsigned t;
        t = 32'(a) + 32'(b);
        t = (t & 32'h0000_FFFF) + (t >> 16);
        return sum_t'(t);
    endfunction

    // Fold one word into a message accumulator
    function automatic void absorb_word(inout msg_acc_t acc, input word_item_t it);
        sum_t        data;
        int unsigned total;
        data = it.single_byte ? {it.word[15:8], 8'h00} : it.word;
        acc.sum = ones_add(acc.sum, data);
        if (it.cmd == CMD_MSG)
        begin
            total = 32'(acc.count) + (it.single_byte ? 1 : 2);
            if (total > 32'(COUNT_MAX))
            begin
                acc.count = COUNT_MAX;
                acc.ovf   = 1'b1;
            end
            else
                acc.count = count_t'(total);
        end
    endfunction

    // Close a message: pseudo-header tail in v6, invert, clear for the next one
    function automatic cs_result_t close_message(inout msg_acc_t acc, input logic v6);
        logic [31:0] len;
        cs_result_t  r;
        if (v6 == MODE_V6)
        begin
            len = 32'(acc.count);
            acc.sum = ones_add(acc.sum, len[31:16]);
            acc.sum = ones_add(acc.sum, len[15:0]);
            acc.sum = ones_add(acc.sum, ICMPV6_NEXT_HDR);
        end
        r.chk      = ~acc.sum;
        r.ok       = (r.chk == '0);
        r.too_long = acc.ovf;
        acc = '0;
        return r;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random message: mostly well formed, some self-verifying, some noise
    function automatic void build_message(ref word_item_t msg[$]);
        int         kind;
        int         n_addr;
        int         n_body;
        word_item_t it;
        msg_acc_t   scratch;
        cs_result_t r;
        msg.delete();
        kind   = $urandom_range(0, 9);
        n_addr = 0;
        if (kind >= 8)
        begin
            n_body = $urandom_range(1, 6);
            repeat (n_body)
            begin
                it.cmd         = 1'($urandom_range(0, 1));
                it.word        = rand_word();
                it.single_byte = 1'($urandom_range(0, 1));
                it.last        = 1'b0;
                msg.push_back(it);
            end
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       n_addr = 0;
                1:       n_addr = 16;
                default: n_addr = $urandom_range(0, 4);
            endcase
            n_body = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
            repeat (n_addr)
            begin
                it = '{CMD_ADDR, rand_word(), 1'b0, 1'b0};
                msg.push_back(it);
            end
            repeat (n_body)
            begin
                it = '{CMD_MSG, rand_word(), 1'b0, 1'b0};
                msg.push_back(it);
            end
            if ($urandom_range(0, 2) == 0)
                msg[msg.size()-1].single_byte = 1'b1;
        end
        msg[msg.size()-1].last = 1'b1;

        // Fill the first body word with the checksum so the message verifies
        if ((kind == 6 || kind == 7) && !msg[n_addr].single_byte)
        begin
            msg[n_addr].word = '0;
            scratch = '0;
            foreach (msg[k])
                absorb_word(scratch, msg[k]);
            r = close_message(scratch, mode_cfg);
            msg[n_addr].word = r.chk;
        end
    endfunction

    // One input transfer; the predictor runs when it is accepted
    task automatic send_word(input word_item_t it, input logic typed, input cs_result_t typed_res);
        cs_result_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= it.cmd;
        word        <= it.word;
        single_byte <= it.single_byte;
        last        <= it.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb_word(msg_acc, it);
        words_sent++;
        if (it.last)
        begin
            r = close_message(msg_acc, mode_cfg);
            cs_expect_q.push_back(typed ? typed_res : r);
        end
    endtask

    // Register write once every result is out and the pipeline has settled
    task automatic set_mode(input logic m);
        @(negedge clk);
        in_valid <= 1'b0;
        while (cs_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode_cfg = m;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_batch(input logic m, input int n_items);
        word_item_t msg[$];
        int         sent;
        set_mode(m);
        sent = 0;
        while (sent < n_items)
        begin
            build_message(msg);
            foreach (msg[k])
                send_word(msg[k], 1'b0, NO_RES);
            sent += msg.size();
        end
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        cs_result_t got;
        cs_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.chk      = checksum;
            got.ok       = checksum_ok;
            got.too_long = too_long;
            results_seen++;
            ok_seen   += int'(got.ok);
            long_seen += int'(got.too_long);
            if (cs_expect_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected result checksum %h ok %0b too_long %0b",
                             $time, got.chk, got.ok, got.too_long);
                mismatches++;
            end
            else
            begin
                want = cs_expect_q.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                        $display("%0t: exp chk %h ok %0b long %0b, got chk %h ok %0b long %0b",
                                 $time, want.chk, want.ok, want.too_long,
                                 got.chk, got.ok, got.too_long);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int guard;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        in_valid    = 1'b0;
        cmd         = CMD_MSG;
        word        = '0;
        single_byte = 1'b0;
        last        = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++)
        begin
            // sender idles 21 / receiver 55, then swapped, then neither
            case (ph)
                0:
                begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 55;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 21;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            if (ph == 0)
            begin
                for (int i = 0; i < NUM_DIR; i++)
                begin
                    if (i == 0 || dir_tbl[i].mode != mode_cfg)
                        set_mode(dir_tbl[i].mode);
                    send_word(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].res);
                end
            end

            run_batch(MODE_V6, 100);
            run_batch(MODE_V4, 100);
            run_batch(1'($urandom_range(0, 1)), 100);
        end

        // drain, then allow for the pipeline latency
        @(negedge clk);
        in_valid <= 1'b0;
        guard = 0;
        while (cs_expect_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (cs_expect_q.size() != 0)
        begin
            $display("%0d expected results never arrived", cs_expect_q.size());
            mismatches++;
        end

        $display("Sent %0d words over %0d mode writes, both modes, with and without stalls",
                 words_sent, cfg_writes);
        $display("Checked %0d checksums: %0d verifying, %0d with saturated length",
                 results_seen, ok_seen, long_seen);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
src/icmp_cs_pkg.sv
src/icmp_cs_accum.sv
src/icmp_cs_final.sv
src/icmp_internet_checksum.sv
dv/tb.sv
